### sv/rsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared sizes, types, codes and the modular-reduction table of the rotor
// substitution cipher.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int ROTOR_SIZE  = 26;
    localparam int ROTOR_COUNT = 7;
    localparam int LETTER_BASE = 65;

    localparam int IDX_W     = (ROTOR_SIZE > 1) ? $clog2(ROTOR_SIZE) : 1;
    localparam int ROT_W     = 3;
    localparam int OFF_W     = 6;
    localparam int ADDR_W    = ROT_W + IDX_W;
    localparam int MEM_DEPTH = ROTOR_COUNT << IDX_W;
    localparam int MOD_TBL_N = 128;

    localparam logic [IDX_W:0] SIZE_X = (IDX_W + 1)'(ROTOR_SIZE);

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [ROT_W-1:0]  t_rotor;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [OFF_W-1:0]  t_off;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_LOAD      = 2'd0;
    localparam t_opcode OP_ROTATE    = 2'd1;
    localparam t_opcode OP_TRANSLATE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROTATE,
        ST_TR_ADDR,
        ST_TR_DATA,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic  we;
        logic  re;
        t_addr addr;
        t_off  wdata;
    } t_mem_req;

    // maps a 7-bit two's complement value onto 0..ROTOR_SIZE-1
    typedef t_idx t_mod_tbl [0:MOD_TBL_N-1];

    function automatic t_mod_tbl build_mod_tbl();
        t_mod_tbl tbl;
        int       v;
        int       r;
        for (int k = 0; k < MOD_TBL_N; k++) begin
            v = (k < MOD_TBL_N / 2) ? k : k - MOD_TBL_N;
            r = v % ROTOR_SIZE;
            if (r < 0) begin
                r = r + ROTOR_SIZE;
            end
            tbl[k] = IDX_W'(r);
        end
        return tbl;
    endfunction

    localparam t_mod_tbl MOD_TBL = build_mod_tbl();

endpackage

### sv/rsc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_in_if / rsc_out_if
// Valid/ready channels carrying command words in and translated letters out.
// ----------------------------------------------------------------------------
interface rsc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [2:0]        rotor_select;
    logic [4:0]        entry_position;
    logic signed [5:0] entry_offset;
    logic signed [6:0] rotate_amount;
    logic [7:0]        letter;

    modport source (
        output valid, opcode, rotor_select, entry_position, entry_offset,
               rotate_amount, letter,
        input  ready
    );
    modport sink (
        input  valid, opcode, rotor_select, entry_position, entry_offset,
               rotate_amount, letter,
        output ready
    );
endinterface

interface rsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_letter;
    logic       bad_letter;

    modport source (
        output valid, out_letter, bad_letter,
        input  ready
    );
    modport sink (
        input  valid, out_letter, bad_letter,
        output ready
    );
endinterface

### sv/rsc_rotor_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_rotor_mem
// Rotor table storage: one write and one registered read per cycle, with a
// valid bit per entry so that never-written entries read as zero.
// ----------------------------------------------------------------------------
module rsc_rotor_mem
    import rsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_off     o_rdata
);

    t_off                 r_mem [0:MEM_DEPTH-1];
    logic [MEM_DEPTH-1:0] r_valid;
    t_off                 r_rdata;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_valid <= r_valid[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

### sv/rotor_substitution_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotor_substitution_cipher_top
// Seven-rotor substitution: load table entries, turn rotors, translate letters.
// A translate walks the rotors in order, an address and a data state per
// rotor through the one table read port and the shared add/wrap unit, then
// the done state registers the word; a bad letter goes straight to done. A
// new word is accepted only in idle, and a stalled output word holds input.
// Reset clears rotor positions and table valid bits at once.
// ----------------------------------------------------------------------------
module rotor_substitution_cipher_top
    import rsc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    rsc_in_if.sink    i_in,
    rsc_out_if.source o_out
);

    t_state   r_state;
    t_state   n_state;

    t_opcode  r_opcode;
    t_rotor   r_sel;
    logic [4:0] r_position;
    t_off     r_offset;
    logic [6:0] r_amount;
    t_rotor   r_rotor;
    t_idx     r_idx;
    logic     r_bad;
    t_idx     r_pos [0:ROTOR_COUNT-1];

    logic       r_out_valid;
    logic [7:0] r_out_letter;
    logic       r_out_bad;

    t_mem_req   mem_req;
    t_off       mem_rdata;

    logic       in_fire;
    logic       out_free;
    logic       sel_ok;
    logic       position_ok;
    logic       letter_ok;
    logic [7:0] letter_idx;
    t_rotor     cur_rotor;
    t_idx       cur_pos;
    t_idx       slot_base;
    logic [IDX_W:0] slot_diff;
    t_idx       slot;
    logic [6:0] off_sum;
    t_idx       rot_mod;
    logic [IDX_W:0] rot_sum;
    t_idx       rot_new;
    logic       last_rotor;

    rsc_rotor_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign letter_idx = i_in.letter - 8'(LETTER_BASE);
    assign letter_ok  = (i_in.letter >= 8'(LETTER_BASE)) &&
                        (letter_idx < 8'(ROTOR_SIZE));

    assign sel_ok      = (r_sel < ROT_W'(ROTOR_COUNT));
    assign position_ok = ({1'b0, r_position} < 6'(ROTOR_SIZE));

    // translate walks the rotor counter, load and rotate use the selected one
    assign cur_rotor = (r_opcode == OP_TRANSLATE) ? r_rotor : r_sel;
    assign cur_pos   = (cur_rotor < ROT_W'(ROTOR_COUNT)) ? r_pos[cur_rotor] : '0;

    // physical slot = logical position minus turn count, wrapped once
    assign slot_base = (r_opcode == OP_TRANSLATE) ? r_idx : r_position[IDX_W-1:0];
    assign slot_diff = {1'b0, slot_base} - {1'b0, cur_pos};
    assign slot      = slot_diff[IDX_W] ? IDX_W'(slot_diff + SIZE_X)
                                        : slot_diff[IDX_W-1:0];

    assign off_sum    = 7'(r_idx) + {mem_rdata[OFF_W-1], mem_rdata};
    assign last_rotor = (r_rotor == ROT_W'(ROTOR_COUNT - 1));

    assign rot_mod = MOD_TBL[r_amount];
    assign rot_sum = {1'b0, cur_pos} + {1'b0, rot_mod};
    assign rot_new = (rot_sum >= SIZE_X) ? IDX_W'(rot_sum - SIZE_X)
                                         : rot_sum[IDX_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.opcode)
                        OP_LOAD:      n_state = ST_LOAD;
                        OP_ROTATE:    n_state = ST_ROTATE;
                        OP_TRANSLATE: n_state = letter_ok ? ST_TR_ADDR : ST_DONE;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:    n_state = ST_IDLE;
            ST_ROTATE:  n_state = ST_IDLE;
            ST_TR_ADDR: n_state = ST_TR_DATA;
            ST_TR_DATA: n_state = last_rotor ? ST_DONE : ST_TR_ADDR;
            ST_DONE:    n_state = out_free ? ST_IDLE : ST_DONE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_in.ready    = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.addr  = {cur_rotor, slot};
        mem_req.wdata = r_offset;
        unique case (r_state)
            ST_IDLE:    i_in.ready = 1'b1;
            ST_LOAD:    mem_req.we = sel_ok && position_ok;
            ST_TR_ADDR: mem_req.re = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_opcode    <= OP_LOAD;
            r_out_valid <= 1'b0;
            for (int k = 0; k < ROTOR_COUNT; k++) begin
                r_pos[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_opcode <= i_in.opcode;
                    end
                end
                ST_ROTATE: begin
                    if (sel_ok) begin
                        r_pos[r_sel] <= rot_new;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_sel      <= i_in.rotor_select;
                    r_position <= i_in.entry_position;
                    r_offset   <= i_in.entry_offset;
                    r_amount   <= i_in.rotate_amount;
                    r_rotor    <= '0;
                    r_idx      <= letter_idx[IDX_W-1:0];
                    r_bad      <= !letter_ok;
                end
            end
            ST_TR_DATA: begin
                r_idx   <= MOD_TBL[off_sum];
                r_rotor <= r_rotor + 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_letter <= r_bad ? 8'd0 : 8'(LETTER_BASE) + 8'(r_idx);
                    r_out_bad    <= r_bad;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_letter = r_out_letter;
    assign o_out.bad_letter = r_out_bad;

    // rotor counter stays on a real rotor while walking the chain
    a_rotor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TR_ADDR || r_state == ST_TR_DATA)
            |-> (r_rotor < ROT_W'(ROTOR_COUNT)))
        else $error("rotor counter out of range");

    // running index is always a reduced position
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TR_ADDR || r_state == ST_TR_DATA)
            |-> ({1'b0, r_idx} < SIZE_X))
        else $error("translate index not reduced");

    // a finished translate always lands a word in the output register
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("translate result not delivered");

    // rotor positions never leave the rotor range
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == ST_ROTATE) |-> ({1'b0, cur_pos} < SIZE_X))
        else $error("rotor position out of range");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the rotor substitution cipher against its own predictor of the rotor
// tables and turn counts. Table loads, rotor turns, translations and unused
// codes are driven over the command channel. Each translated letter is
// compared, field by field, with the oldest predicted one. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import rsc_pkg::*;

    localparam t_opcode OP_UNUSED     = 2'd3;
    localparam t_rotor  ROTOR_NONE    = 3'd7;
    localparam int      IDLE_PCT      = 18;
    localparam int      CALM_FROM     = 300;
    localparam int      CALM_TO       = 460;
    localparam int      RANDOM_ITEMS  = 850;
    localparam int      DRAIN_CYCLES  = 40;
    localparam int      STALL_LIMIT   = 2000;

    typedef struct {
        t_opcode           opcode;
        t_rotor            rotor;
        logic [4:0]        position;
        logic signed [5:0] offset;
        logic signed [6:0] amount;
        logic [7:0]        letter;
        bit                hold;   // wait for all letters out before sending
    } t_cipher_cmd;

    typedef struct {
        logic [7:0] out_letter;
        logic       bad_letter;
    } t_cipher_letter;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rsc_in_if  in_ch ();
    rsc_out_if out_ch ();

    rotor_substitution_cipher_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_cipher_cmd    cmd_q[$];
    t_cipher_letter letters_due[$];
    t_cipher_cmd    cur_cmd;

    logic signed [5:0] rotor_offsets [ROTOR_COUNT][ROTOR_SIZE];
    int                rotor_turns   [ROTOR_COUNT];

    int n_sent     = 0;
    int n_accepted = 0;
    int n_fails    = 0;
    int stall_cnt  = 0;

    function automatic int wrap_idx(input int v);
        int r;
        r = v % ROTOR_SIZE;
        if (r < 0) begin
            r = r + ROTOR_SIZE;
        end
        return r;
    endfunction

    // advance the cipher state by one accepted word, queue any letter it gives
    function automatic void apply_cipher_cmd(input t_cipher_cmd c);
        t_cipher_letter res;
        int             idx;
        int             ltr;
        idx = 0;
        ltr = int'(c.letter);
        case (c.opcode)
            OP_LOAD: begin
                if (int'(c.rotor) < ROTOR_COUNT && int'(c.position) < ROTOR_SIZE) begin
                    rotor_offsets[c.rotor][wrap_idx(int'(c.position)
                        - rotor_turns[c.rotor])] = c.offset;
                end
            end
            OP_ROTATE: begin
                if (int'(c.rotor) < ROTOR_COUNT) begin
                    rotor_turns[c.rotor] = wrap_idx(rotor_turns[c.rotor]
                        + wrap_idx(int'(c.amount)));
                end
            end
            OP_TRANSLATE: begin
                if (ltr < LETTER_BASE || ltr - LETTER_BASE >= ROTOR_SIZE) begin
                    res.out_letter = 8'd0;
                    res.bad_letter = 1'b1;
                end else begin
                    idx = ltr - LETTER_BASE;
                    for (int r = 0; r < ROTOR_COUNT; r++) begin
                        idx = wrap_idx(idx + int'(rotor_offsets[r][wrap_idx(idx
                            - rotor_turns[r])]));
                    end
                    res.out_letter = 8'(LETTER_BASE + idx);
                    res.bad_letter = 1'b0;
                end
                letters_due.push_back(res);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_cipher_cmd make_cmd(input t_opcode op, input int sel,
                                             input int pos, input int off,
                                             input int amt, input int ltr);
        t_cipher_cmd c;
        c.opcode   = op;
        c.rotor    = t_rotor'(sel);
        c.position = 5'(pos);
        c.offset   = 6'(off);
        c.amount   = 7'(amt);
        c.letter   = 8'(ltr);
        c.hold     = 1'b0;
        return c;
    endfunction

    // every field random, so unused fields toggle as well
    function automatic t_cipher_cmd random_cmd();
        return make_cmd(t_opcode'($urandom_range(0, 3)), $urandom_range(0, 7),
                        $urandom_range(0, 31), $urandom_range(0, 63),
                        $urandom_range(0, 127), $urandom_range(0, 255));
    endfunction

    // command driver
    always @(posedge i_clk) begin
        bit calm;
        bit go;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                apply_cipher_cmd(cur_cmd);
                n_accepted++;
            end
            if (!(in_ch.valid && !in_ch.ready)) begin
                calm = (n_sent >= CALM_FROM && n_sent < CALM_TO);
                go = cmd_q.size() != 0
                     && !(cmd_q[0].hold && letters_due.size() != 0)
                     && (calm || $urandom_range(0, 99) >= IDLE_PCT);
                if (go) begin
                    cur_cmd = cmd_q.pop_front();
                    n_sent++;
                    in_ch.opcode         <= cur_cmd.opcode;
                    in_ch.rotor_select   <= cur_cmd.rotor;
                    in_ch.entry_position <= cur_cmd.position;
                    in_ch.entry_offset   <= cur_cmd.offset;
                    in_ch.rotate_amount  <= cur_cmd.amount;
                    in_ch.letter         <= cur_cmd.letter;
                end
                in_ch.valid <= go;
            end
        end
    end

    // letter monitor
    always @(posedge i_clk) begin
        t_cipher_letter want;
        bit             calm;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (letters_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual letter %0d bad %0b",
                             $time, out_ch.out_letter, out_ch.bad_letter);
                    n_fails++;
                end else begin
                    want = letters_due.pop_front();
                    if (out_ch.out_letter !== want.out_letter) begin
                        $display("%0t: out_letter expected %0d actual %0d",
                                 $time, want.out_letter, out_ch.out_letter);
                        n_fails++;
                    end
                    if (out_ch.bad_letter !== want.bad_letter) begin
                        $display("%0t: bad_letter expected %0b actual %0b",
                                 $time, want.bad_letter, out_ch.bad_letter);
                        n_fails++;
                    end
                end
            end
            calm = (n_sent >= CALM_FROM && n_sent < CALM_TO);
            out_ch.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        t_cipher_cmd c;
        int          pick;
        int          total;
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.opcode         = OP_LOAD;
        in_ch.rotor_select   = '0;
        in_ch.entry_position = '0;
        in_ch.entry_offset   = '0;
        in_ch.rotate_amount  = '0;
        in_ch.letter         = '0;
        out_ch.ready         = 1'b0;
        for (int r = 0; r < ROTOR_COUNT; r++) begin
            rotor_turns[r] = 0;
            for (int i = 0; i < ROTOR_SIZE; i++) begin
                rotor_offsets[r][i] = '0;
            end
        end

        // directed: empty tables, letter edges, offset and turn extremes
        cmd_q.push_back(make_cmd(OP_TRANSLATE, 0, 0, 0, 0, "A"));
        cmd_q.push_back(make_cmd(OP_TRANSLATE, 0, 0, 0, 0, "Z"));
        cmd_q.push_back(make_cmd(OP_TRANSLATE, 0, 0, 0, 0, "@"));
        cmd_q.push_back(make_cmd(OP_TRANSLATE, 0, 0, 0, 0, "["));
        cmd_q.push_back(make_cmd(OP_TRANSLATE, 0, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_TRANSLATE, 0, 0, 0, 0, 255));
        cmd_q.push_back(make_cmd(OP_LOAD, 0, 0, 25, 0, 0));
        cmd_q.push_back(make_cmd(OP_LOAD, 0, 25, -25, 0, 0));
        cmd_q.push_back(make_cmd(OP_LOAD, 3, 13, 31, 0, 0));       // large offset
        cmd_q.push_back(make_cmd(OP_LOAD, 6, 12, -32, 0, 0));
        cmd_q.push_back(make_cmd(OP_LOAD, 2, 31, 5, 0, 0));        // position past end
        cmd_q.push_back(make_cmd(OP_LOAD, 1, 26, 9, 0, 0));
        cmd_q.push_back(make_cmd(OP_LOAD, ROTOR_NONE, 3, 7, 0, 0));
        cmd_q.push_back(make_cmd(OP_TRANSLATE, 0, 0, 0, 0, "A"));
        cmd_q.push_back(make_cmd(OP_ROTATE, 0, 0, 0, 63, 0));
        cmd_q.push_back(make_cmd(OP_ROTATE, 6, 0, 0, -64, 0));
        cmd_q.push_back(make_cmd(OP_ROTATE, ROTOR_NONE, 0, 0, 5, 0));
        cmd_q.push_back(make_cmd(OP_ROTATE, 3, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(OP_UNUSED, 1, 4, 3, 2, "B"));
        cmd_q.push_back(make_cmd(OP_TRANSLATE, 0, 0, 0, 0, "A"));
        cmd_q.push_back(make_cmd(OP_TRANSLATE, 0, 0, 0, 0, "M"));
        cmd_q.push_back(make_cmd(OP_TRANSLATE, 0, 0, 0, 0, "Z"));

        // random: mostly sensible loads, turns and letters, some noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            c = random_cmd();
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                c.opcode = OP_LOAD;
                if ($urandom_range(0, 9) != 0) begin
                    c.rotor    = t_rotor'($urandom_range(0, ROTOR_COUNT - 1));
                    c.position = 5'($urandom_range(0, ROTOR_SIZE - 1));
                    if ($urandom_range(0, 3) != 0) begin
                        c.offset = 6'($urandom_range(0, 2 * ROTOR_SIZE - 2)
                                      - (ROTOR_SIZE - 1));
                    end
                end
            end else if (pick < 40) begin
                c.opcode = OP_ROTATE;
                if ($urandom_range(0, 9) != 0) begin
                    c.rotor = t_rotor'($urandom_range(0, ROTOR_COUNT - 1));
                end
            end else if (pick < 95) begin
                c.opcode = OP_TRANSLATE;
                if ($urandom_range(0, 9) != 0) begin
                    c.letter = 8'(LETTER_BASE + $urandom_range(0, ROTOR_SIZE - 1));
                end
            end else begin
                c.opcode = OP_UNUSED;
            end
            c.hold = (n == 0 || n == 500);
            cmd_q.push_back(c);
        end
        total = cmd_q.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < total) @(posedge i_clk);
        while (letters_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/rsc_pkg.sv
sv/rsc_if.sv
sv/rsc_rotor_mem.sv
sv/rotor_substitution_cipher_top.sv
tb/tb_top.sv
